// ----- hdl/sdci_pkg.sv -----
// ----------------------------------------------------------------------------
// SD card init sequencer package
// Event, status, error and command codes, plus the CSD capacity decode.
// ----------------------------------------------------------------------------
package sdci_pkg;

  // Input events (s_axis_tuser)
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_OK    = 2'd1;
  localparam logic [1:0] OP_FAIL  = 2'd2;

  // Result status (m_axis_tuser)
  localparam logic [1:0] STATUS_ISSUE  = 2'd0;
  localparam logic [1:0] STATUS_READY  = 2'd1;
  localparam logic [1:0] STATUS_FAILED = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_CMD_FAIL  = 2'd1;
  localparam logic [1:0] ERR_CHECK     = 2'd2;
  localparam logic [1:0] ERR_EXHAUSTED = 2'd3;

  // Expected response kinds
  localparam logic [1:0] RESP_NONE     = 2'd0;
  localparam logic [1:0] RESP_R136     = 2'd1;
  localparam logic [1:0] RESP_R48      = 2'd2;
  localparam logic [1:0] RESP_R48_BUSY = 2'd3;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
  localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;

  localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
  localparam logic [7:0]  CHECK_PATTERN = 8'hAA;

  // Configuration register indexes
  localparam logic [1:0] REG_OP_COND_TRIES    = 2'd0;
  localparam logic [1:0] REG_OP_COND_ARGUMENT = 2'd1;
  localparam logic [1:0] REG_BLOCK_LENGTH     = 2'd2;
  localparam logic [1:0] REG_FALLBACK_SECTORS = 2'd3;

  localparam logic [7:0]  RST_OP_COND_TRIES    = 8'd100;
  localparam logic [31:0] RST_OP_COND_ARGUMENT = 32'h40FF_8000;
  localparam logic [15:0] RST_BLOCK_LENGTH     = 16'd512;
  localparam logic [31:0] RST_FALLBACK_SECTORS = 32'd131072;

  // Decode card size in 512-byte sectors from the CSD, saturated at 32 bits.
  // Version 1 overflows only for the largest C_SIZE; version 0 tops out at 2^27.
  function automatic logic [31:0] decode_capacity(input logic [31:0] w1,
                                                  input logic [31:0] w2,
                                                  input logic [31:0] w3,
                                                  input logic [31:0] fallback);
    logic [1:0]  ver;
    logic [32:0] v1_size;
    logic [12:0] cs;
    logic [4:0]  sh;
    logic [36:0] v0_bytes;
    logic [31:0] res;
    ver      = w3[23:22];
    v1_size  = {1'b0, ({10'd0, w1[29:8]} + 32'd1)} << 10;
    cs       = {1'b0, w2[1:0], w1[31:22]} + 13'd1;
    sh       = {2'b00, w1[9:7]} + 5'd2 + {1'b0, w2[11:8]};
    v0_bytes = {24'd0, cs} << sh;
    case (ver)
      2'd0:    res = {4'd0, v0_bytes[36:9]};
      2'd1:    res = v1_size[32] ? 32'hFFFF_FFFF : v1_size[31:0];
      default: res = fallback;
    endcase
    return res;
  endfunction

endpackage

// ----- hdl/sd_card_init_sequencer.sv -----
// ----------------------------------------------------------------------------
// SD card init sequencer
// Walks an SD card through identification, one completion event per item.
// ----------------------------------------------------------------------------
// Feed one event per transaction on the slave side: start, command done or
// command failed, with the response words of the finished command. Each event
// yields at most one result: the next command to issue (index, argument,
// expected response kind and checks), card ready, or failed with an error
// code; every result also carries the card address, capacity flag and sector
// count learned so far. An event passes through the input register and then
// the result register, and a new event is taken every cycle as long as the
// master side keeps up; the result register holds a result while the next
// event waits in the input register. Write the configuration registers only
// while no event is in flight.
module sd_card_init_sequencer (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i,
  // event input
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: resp_word0[31:0], resp_word1[63:32], resp_word2[95:64],
  //        resp_word3[127:96]
  input  logic [127:0] s_axis_tdata_i,
  // tuser: op[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  // result output
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: cmd_index[5:0], cmd_argument[37:6], resp_kind[39:38],
  //        crc_check[40], index_check[41], error_code[43:42],
  //        high_capacity[44], card_address[60:45], capacity_sectors[92:61],
  //        zero pad[95:93]
  output logic [95:0]  m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser_o
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_CMD0   = 4'd1;
  localparam logic [3:0] PH_CMD8   = 4'd2;
  localparam logic [3:0] PH_CMD55  = 4'd3;
  localparam logic [3:0] PH_ACMD41 = 4'd4;
  localparam logic [3:0] PH_CMD2   = 4'd5;
  localparam logic [3:0] PH_CMD3   = 4'd6;
  localparam logic [3:0] PH_CMD9   = 4'd7;
  localparam logic [3:0] PH_CMD7   = 4'd8;
  localparam logic [3:0] PH_CMD16  = 4'd9;
  localparam logic [3:0] PH_READY  = 4'd10;
  localparam logic [3:0] PH_FAILED = 4'd11;

  // Configuration registers
  logic [7:0]  op_cond_tries_q;
  logic [31:0] op_cond_argument_q;
  logic [15:0] block_length_q;
  logic [31:0] fallback_sectors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_cond_tries_q    <= sdci_pkg::RST_OP_COND_TRIES;
      op_cond_argument_q <= sdci_pkg::RST_OP_COND_ARGUMENT;
      block_length_q     <= sdci_pkg::RST_BLOCK_LENGTH;
      fallback_sectors_q <= sdci_pkg::RST_FALLBACK_SECTORS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sdci_pkg::REG_OP_COND_TRIES:    op_cond_tries_q    <= cfg_wdata_i[7:0];
        sdci_pkg::REG_OP_COND_ARGUMENT: op_cond_argument_q <= cfg_wdata_i;
        sdci_pkg::REG_BLOCK_LENGTH:     block_length_q     <= cfg_wdata_i[15:0];
        sdci_pkg::REG_FALLBACK_SECTORS: fallback_sectors_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic         in_valid_q;
  logic [1:0]   in_op_q;
  logic [127:0] in_words_q;
  logic         advance;

  // Result register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [95:0] out_data_q;

  // Sequencer state
  logic [3:0]  phase_q, phase_d;
  logic [7:0]  tries_q, tries_d;
  logic [15:0] rca_q, rca_d;
  logic        hc_q, hc_d;
  logic [31:0] sectors_q, sectors_d;

  // Result fields for the event in the input register
  logic        emit;
  logic [1:0]  status;
  logic [5:0]  cmd_idx;
  logic [31:0] cmd_arg;
  logic [1:0]  kind;
  logic        crc_chk;
  logic        idx_chk;
  logic [1:0]  err;
  logic        waiting;
  logic [7:0]  tries_inc;
  logic [31:0] w0, w1, w2, w3;

  // Move an event forward whenever the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign w0 = in_words_q[31:0];
  assign w1 = in_words_q[63:32];
  assign w2 = in_words_q[95:64];
  assign w3 = in_words_q[127:96];

  assign waiting   = (phase_q >= PH_CMD0) && (phase_q <= PH_CMD16);
  assign tries_inc = (tries_q == 8'hFF) ? tries_q : tries_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    tries_d   = tries_q;
    rca_d     = rca_q;
    hc_d      = hc_q;
    sectors_d = sectors_q;
    emit      = 1'b0;
    status    = sdci_pkg::STATUS_ISSUE;
    cmd_idx   = sdci_pkg::CMD_GO_IDLE;
    cmd_arg   = 32'd0;
    kind      = sdci_pkg::RESP_NONE;
    crc_chk   = 1'b0;
    idx_chk   = 1'b0;
    err       = sdci_pkg::ERR_NONE;
    if (in_op_q == sdci_pkg::OP_START) begin
      // Restart from scratch in any phase.
      emit      = 1'b1;
      phase_d   = PH_CMD0;
      tries_d   = 8'd0;
      rca_d     = 16'd0;
      hc_d      = 1'b0;
      sectors_d = 32'd0;
    end else if (waiting && in_op_q == sdci_pkg::OP_FAIL) begin
      emit    = 1'b1;
      phase_d = PH_FAILED;
      status  = sdci_pkg::STATUS_FAILED;
      err     = sdci_pkg::ERR_CMD_FAIL;
    end else if (waiting && in_op_q == sdci_pkg::OP_OK) begin
      emit    = 1'b1;
      kind    = sdci_pkg::RESP_R48;
      crc_chk = 1'b1;
      idx_chk = 1'b1;
      case (phase_q)
        PH_CMD0: begin
          phase_d = PH_CMD8;
          cmd_idx = sdci_pkg::CMD_IF_COND;
          cmd_arg = sdci_pkg::IF_COND_ARG;
        end
        PH_CMD8: begin
          if (w0[7:0] != sdci_pkg::CHECK_PATTERN) begin
            phase_d = PH_FAILED;
            status  = sdci_pkg::STATUS_FAILED;
            err     = sdci_pkg::ERR_CHECK;
            kind    = sdci_pkg::RESP_NONE;
            crc_chk = 1'b0;
            idx_chk = 1'b0;
          end else begin
            hc_d    = 1'b0;
            tries_d = 8'd0;
            phase_d = PH_CMD55;
            cmd_idx = sdci_pkg::CMD_APP;
          end
        end
        PH_CMD55: begin
          phase_d = PH_ACMD41;
          cmd_idx = sdci_pkg::CMD_OP_COND;
          cmd_arg = op_cond_argument_q;
          crc_chk = 1'b0;
          idx_chk = 1'b0;
        end
        PH_ACMD41: begin
          tries_d = tries_inc;
          if (w0[31]) begin
            hc_d    = w0[30];
            phase_d = PH_CMD2;
            cmd_idx = sdci_pkg::CMD_ALL_CID;
            kind    = sdci_pkg::RESP_R136;
            idx_chk = 1'b0;
          end else if (tries_inc >= op_cond_tries_q) begin
            phase_d = PH_FAILED;
            status  = sdci_pkg::STATUS_FAILED;
            err     = sdci_pkg::ERR_EXHAUSTED;
            kind    = sdci_pkg::RESP_NONE;
            crc_chk = 1'b0;
            idx_chk = 1'b0;
          end else begin
            phase_d = PH_CMD55;
            cmd_idx = sdci_pkg::CMD_APP;
          end
        end
        PH_CMD2: begin
          phase_d = PH_CMD3;
          cmd_idx = sdci_pkg::CMD_SEND_RCA;
        end
        PH_CMD3: begin
          rca_d   = w0[31:16];
          phase_d = PH_CMD9;
          cmd_idx = sdci_pkg::CMD_SEND_CSD;
          cmd_arg = {w0[31:16], 16'd0};
          kind    = sdci_pkg::RESP_R136;
          idx_chk = 1'b0;
        end
        PH_CMD9: begin
          sectors_d = sdci_pkg::decode_capacity(w1, w2, w3, fallback_sectors_q);
          phase_d   = PH_CMD7;
          cmd_idx   = sdci_pkg::CMD_SELECT;
          cmd_arg   = {rca_q, 16'd0};
          kind      = sdci_pkg::RESP_R48_BUSY;
        end
        PH_CMD7: begin
          phase_d = PH_CMD16;
          cmd_idx = sdci_pkg::CMD_BLOCKLEN;
          cmd_arg = {16'd0, block_length_q};
        end
        default: begin
          // CMD16 done: card is ready.
          phase_d = PH_READY;
          status  = sdci_pkg::STATUS_READY;
          kind    = sdci_pkg::RESP_NONE;
          crc_chk = 1'b0;
          idx_chk = 1'b0;
        end
      endcase
    end
  end

  // Input register: load on every accepted transaction, drop once advanced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q    <= s_axis_tuser_i;
      in_words_q <= s_axis_tdata_i;
    end
  end

  // Sequencer state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tries_q     <= 8'd0;
      rca_q       <= 16'd0;
      hc_q        <= 1'b0;
      sectors_q   <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q   <= phase_d;
        tries_q   <= tries_d;
        rca_q     <= rca_d;
        hc_q      <= hc_d;
        sectors_q <= sectors_d;
      end
      if (advance) begin
        out_valid_q <= emit;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_status_q <= status;
      out_data_q   <= {3'b000, sectors_d, rca_d, hc_d, err, idx_chk, crc_chk,
                       kind, cmd_arg, cmd_idx};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = out_data_q;

  // A start event always lands in the CMD0 phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_op_q == sdci_pkg::OP_START |=> phase_q == PH_CMD0)
    else $error("start event did not enter CMD0 phase");

  // An event that produces a result must show up on the master side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> m_axis_tvalid_o)
    else $error("emitted result not presented");

  // Only a failed result carries an error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != sdci_pkg::STATUS_FAILED
      |-> m_axis_tdata_o[43:42] == sdci_pkg::ERR_NONE)
    else $error("error code set on a non-failed result");

  // Ready and failed results carry no command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != sdci_pkg::STATUS_ISSUE
      |-> m_axis_tdata_o[41:0] == 42'd0)
    else $error("command fields set on a terminal result");

endmodule

// ----- test/sd_card_init_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// SD card init sequencer testbench
// Drives start, completion and failure events into the sequencer and checks
// every result against a cycle-free model of the identification sequence.
// A directed table covers the corner cases. It is followed by phases of
// mostly well-formed random sequences under several register settings; all but the
// last add random idle cycles on the event side and random stalls on the result side.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Event code with no meaning; the sequencer must drop it silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Two-stage pipeline; pad it so that dropped events surely left the block.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned EVENTS_PER_PHASE = 45;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_CMD0, SEQ_CMD8, SEQ_CMD55, SEQ_ACMD41, SEQ_CMD2,
    SEQ_CMD3, SEQ_CMD9, SEQ_CMD7, SEQ_CMD16, SEQ_READY, SEQ_FAILED
  } seq_phase_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [1:0]  kind;
    logic        crc;
    logic        ichk;
    logic [1:0]  err;
    logic        hc;
    logic [15:0] rca;
    logic [31:0] sectors;
  } sd_reply_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] w0, w1, w2, w3;
    bit          typed;     // reply below is written out by hand
    bit          want_made;
    sd_reply_t   want;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic         clk_i = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_valid = 1'b0;
  logic [127:0] s_data = '0;
  logic [1:0]   s_op = sdci_pkg::OP_START;
  logic         m_ready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [95:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  sd_card_init_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_op),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // --------------------------------------------------------------------------
  // Card model state and register shadows
  // --------------------------------------------------------------------------
  seq_phase_e  card_phase = SEQ_IDLE;
  logic [7:0]  acmd41_tries = '0;
  logic [15:0] card_rca = '0;
  logic        card_hc = 1'b0;
  logic [31:0] card_sectors = '0;

  logic [7:0]  cfg_tries = sdci_pkg::RST_OP_COND_TRIES;
  logic [31:0] cfg_opcond_arg = sdci_pkg::RST_OP_COND_ARGUMENT;
  logic [15:0] cfg_blk_len = sdci_pkg::RST_BLOCK_LENGTH;
  logic [31:0] cfg_fallback = sdci_pkg::RST_FALLBACK_SECTORS;

  sd_reply_t   replies_owed[$];
  stim_row_t   directed_rows[$];

  bit          gaps_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned events_sent = 0;
  int unsigned ignored_events = 0;
  int unsigned replies_seen = 0;
  int unsigned ready_seen = 0;
  int unsigned failed_seen = 0;
  int unsigned settings_used = 1;

  // --------------------------------------------------------------------------
  // Clock and reset: reset is held low at start, then released for good
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------
  function automatic sd_reply_t mk_reply(input logic [1:0] status, input logic [5:0] cmd,
                                         input logic [31:0] arg, input logic [1:0] kind,
                                         input logic crc, input logic ichk,
                                         input logic [1:0] err, input logic hc,
                                         input logic [15:0] rca, input logic [31:0] sectors);
    sd_reply_t r;
    r.status  = status;
    r.cmd     = cmd;
    r.arg     = arg;
    r.kind    = kind;
    r.crc     = crc;
    r.ichk    = ichk;
    r.err     = err;
    r.hc      = hc;
    r.rca     = rca;
    r.sectors = sectors;
    return r;
  endfunction

  // Command to issue, carrying what the card has told us so far.
  function automatic sd_reply_t issue_cmd(input logic [5:0] cmd, input logic [31:0] arg,
                                          input logic [1:0] kind, input logic crc,
                                          input logic ichk);
    return mk_reply(sdci_pkg::STATUS_ISSUE, cmd, arg, kind, crc, ichk, sdci_pkg::ERR_NONE,
                    card_hc, card_rca, card_sectors);
  endfunction

  // Ready or failed: command fields zero.
  function automatic sd_reply_t end_sequence(input logic [1:0] status, input logic [1:0] err);
    return mk_reply(status, '0, '0, sdci_pkg::RESP_NONE, 1'b0, 1'b0, err,
                    card_hc, card_rca, card_sectors);
  endfunction

  // Card size in 512-byte sectors from the CSD, worked out at 64 bits.
  function automatic logic [31:0] csd_sectors(input logic [31:0] w1, input logic [31:0] w2,
                                              input logic [31:0] w3);
    logic [63:0] size;
    logic [63:0] csize;
    case (w3[23:22])
      2'd1: begin
        size = ({42'd0, w1[29:8]} + 64'd1) * 64'd1024;
      end
      2'd0: begin
        csize = {52'd0, w2[1:0], w1[31:22]} + 64'd1;
        size  = ((csize << (w1[9:7] + 2)) << w2[11:8]) >> 9;
      end
      default: begin
        size = {32'd0, cfg_fallback};
      end
    endcase
    return (size > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : size[31:0];
  endfunction

  // Advance the card model by one event; made says whether a reply follows.
  task automatic next_card_reply(input logic [1:0] op, input logic [31:0] w0,
                                 input logic [31:0] w1, input logic [31:0] w2,
                                 input logic [31:0] w3, output bit made,
                                 output sd_reply_t rep);
    bit waiting;
    waiting = (card_phase >= SEQ_CMD0) && (card_phase <= SEQ_CMD16);
    made = 1'b1;
    rep  = '0;
    if (op == sdci_pkg::OP_START) begin
      // Restart from any phase: clear what the card told us and reissue CMD0.
      acmd41_tries = '0;
      card_rca     = '0;
      card_hc      = 1'b0;
      card_sectors = '0;
      card_phase   = SEQ_CMD0;
      rep = issue_cmd(sdci_pkg::CMD_GO_IDLE, '0, sdci_pkg::RESP_NONE, 1'b0, 1'b0);
    end else if (op == OP_UNUSED || !waiting) begin
      made = 1'b0;
    end else if (op == sdci_pkg::OP_FAIL) begin
      card_phase = SEQ_FAILED;
      rep = end_sequence(sdci_pkg::STATUS_FAILED, sdci_pkg::ERR_CMD_FAIL);
    end else begin
      case (card_phase)
        SEQ_CMD0: begin
          card_phase = SEQ_CMD8;
          rep = issue_cmd(sdci_pkg::CMD_IF_COND, sdci_pkg::IF_COND_ARG, sdci_pkg::RESP_R48,
                          1'b1, 1'b1);
        end
        SEQ_CMD8: begin
          if (w0[7:0] != sdci_pkg::CHECK_PATTERN) begin
            card_phase = SEQ_FAILED;
            rep = end_sequence(sdci_pkg::STATUS_FAILED, sdci_pkg::ERR_CHECK);
          end else begin
            card_hc      = 1'b0;
            acmd41_tries = '0;
            card_phase   = SEQ_CMD55;
            rep = issue_cmd(sdci_pkg::CMD_APP, '0, sdci_pkg::RESP_R48, 1'b1, 1'b1);
          end
        end
        SEQ_CMD55: begin
          card_phase = SEQ_ACMD41;
          rep = issue_cmd(sdci_pkg::CMD_OP_COND, cfg_opcond_arg, sdci_pkg::RESP_R48,
                          1'b0, 1'b0);
        end
        SEQ_ACMD41: begin
          // Saturating try counter; a limit of zero trips on the first try.
          if (acmd41_tries != 8'hFF) acmd41_tries = acmd41_tries + 8'd1;
          if (w0[31]) begin
            card_hc    = w0[30];
            card_phase = SEQ_CMD2;
            rep = issue_cmd(sdci_pkg::CMD_ALL_CID, '0, sdci_pkg::RESP_R136, 1'b1, 1'b0);
          end else if (acmd41_tries >= cfg_tries) begin
            card_phase = SEQ_FAILED;
            rep = end_sequence(sdci_pkg::STATUS_FAILED, sdci_pkg::ERR_EXHAUSTED);
          end else begin
            card_phase = SEQ_CMD55;
            rep = issue_cmd(sdci_pkg::CMD_APP, '0, sdci_pkg::RESP_R48, 1'b1, 1'b1);
          end
        end
        SEQ_CMD2: begin
          card_phase = SEQ_CMD3;
          rep = issue_cmd(sdci_pkg::CMD_SEND_RCA, '0, sdci_pkg::RESP_R48, 1'b1, 1'b1);
        end
        SEQ_CMD3: begin
          card_rca   = w0[31:16];
          card_phase = SEQ_CMD9;
          rep = issue_cmd(sdci_pkg::CMD_SEND_CSD, {card_rca, 16'h0}, sdci_pkg::RESP_R136,
                          1'b1, 1'b0);
        end
        SEQ_CMD9: begin
          card_sectors = csd_sectors(w1, w2, w3);
          card_phase   = SEQ_CMD7;
          rep = issue_cmd(sdci_pkg::CMD_SELECT, {card_rca, 16'h0}, sdci_pkg::RESP_R48_BUSY,
                          1'b1, 1'b1);
        end
        SEQ_CMD7: begin
          card_phase = SEQ_CMD16;
          rep = issue_cmd(sdci_pkg::CMD_BLOCKLEN, {16'h0, cfg_blk_len}, sdci_pkg::RESP_R48,
                          1'b1, 1'b1);
        end
        default: begin
          card_phase = SEQ_READY;
          rep = end_sequence(sdci_pkg::STATUS_READY, sdci_pkg::ERR_NONE);
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_row(input logic [1:0] op, input logic [31:0] w0, input logic [31:0] w1,
                         input logic [31:0] w2, input logic [31:0] w3, input bit typed,
                         input bit want_made, input sd_reply_t want);
    stim_row_t row;
    row.op        = op;
    row.w0        = w0;
    row.w1        = w1;
    row.w2        = w2;
    row.w3        = w3;
    row.typed     = typed;
    row.want_made = want_made;
    row.want      = want;
    directed_rows.push_back(row);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Present one event, hold it until the transaction happens, then log the
  // reply it owes. A typed row replaces the model's reply with its own.
  task automatic send_event(input logic [1:0] op, input logic [31:0] w0,
                            input logic [31:0] w1, input logic [31:0] w2,
                            input logic [31:0] w3, input bit typed, input bit want_made,
                            input sd_reply_t want, output bit made);
    int unsigned pause;
    sd_reply_t   rep;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      pause = $urandom_range(1, 10);
      s_valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_op    <= op;
    s_data  <= {w3, w2, w1, w0};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    events_sent++;
    next_card_reply(op, w0, w1, w2, w3, made, rep);
    if (typed) begin
      made = want_made;
      rep  = want;
    end
    if (made) replies_owed.push_back(rep);
    else ignored_events++;
  endtask

  // Drop valid, wait for every owed reply, then let dropped events drain.
  task automatic settle();
    s_valid <= 1'b0;
    while (replies_owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back; spare bits above a narrow
  // register carry junk, which the block must ignore.
  task automatic program_regs(input logic [7:0] tries, input logic [31:0] arg,
                              input logic [15:0] blen, input logic [31:0] fb);
    logic [31:0] junk;
    junk = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= sdci_pkg::REG_OP_COND_TRIES;
    cfg_wdata <= {junk[31:8], tries};
    @(posedge clk_i);
    cfg_tries = tries;
    cfg_index <= sdci_pkg::REG_OP_COND_ARGUMENT;
    cfg_wdata <= arg;
    @(posedge clk_i);
    cfg_opcond_arg = arg;
    cfg_index <= sdci_pkg::REG_BLOCK_LENGTH;
    cfg_wdata <= {junk[15:0], blen};
    @(posedge clk_i);
    cfg_blk_len = blen;
    cfg_index <= sdci_pkg::REG_FALLBACK_SECTORS;
    cfg_wdata <= fb;
    @(posedge clk_i);
    cfg_fallback = fb;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic note_mismatch(input string what, input sd_reply_t want, input sd_reply_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
      $display("  want st=%0d cmd=%0d arg=%h kind=%0d crc=%0b ic=%0b err=%0d hc=%0b rca=%h sec=%h",
               want.status, want.cmd, want.arg, want.kind, want.crc, want.ichk, want.err,
               want.hc, want.rca, want.sectors);
      $display("  got  st=%0d cmd=%0d arg=%h kind=%0d crc=%0b ic=%0b err=%0d hc=%0b rca=%h sec=%h",
               got.status, got.cmd, got.arg, got.kind, got.crc, got.ichk, got.err,
               got.hc, got.rca, got.sectors);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, then compare each transaction in order
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sd_reply_t got;
    sd_reply_t want;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      got = mk_reply(m_axis_tuser_o, m_axis_tdata_o[5:0], m_axis_tdata_o[37:6],
                     m_axis_tdata_o[39:38], m_axis_tdata_o[40], m_axis_tdata_o[41],
                     m_axis_tdata_o[43:42], m_axis_tdata_o[44], m_axis_tdata_o[60:45],
                     m_axis_tdata_o[92:61]);
      replies_seen++;
      if (got.status == sdci_pkg::STATUS_READY) ready_seen++;
      if (got.status == sdci_pkg::STATUS_FAILED) failed_seen++;
      if (replies_owed.size() == 0) begin
        note_mismatch("reply with nothing owed", '0, got);
      end else begin
        want = replies_owed.pop_front();
        if (got !== want) note_mismatch("reply differs", want, got);
      end
    end
  end

  // Count cycles without any transaction or register write.
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout: no transaction for %0d cycles, %0d replies owed",
             WATCHDOG_LIMIT, replies_owed.size());
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit          made;
    int unsigned useful;
    int unsigned draw;
    int unsigned ready_pct;
    logic [1:0]  op;
    logic [31:0] w0, w1, w2, w3;

    // Directed table. Hand-typed replies cover reset state, ignored events,
    // error codes and the saturated end result; the rest go to the model.
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b1, 1'b0, '0);     // done while idle
    add_row(sdci_pkg::OP_FAIL, '0, '0, '0, '0, 1'b1, 1'b0, '0);   // fail while idle
    add_row(OP_UNUSED, '1, '1, '1, '1, 1'b1, 1'b0, '0);           // unused code
    add_row(sdci_pkg::OP_START, '1, '1, '1, '1, 1'b1, 1'b1,
            mk_reply(sdci_pkg::STATUS_ISSUE, sdci_pkg::CMD_GO_IDLE, '0, sdci_pkg::RESP_NONE,
                     1'b0, 1'b0, sdci_pkg::ERR_NONE, 1'b0, '0, '0));
    add_row(OP_UNUSED, '0, '0, '0, '0, 1'b1, 1'b0, '0);           // unused while waiting
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b1, 1'b1,
            mk_reply(sdci_pkg::STATUS_ISSUE, sdci_pkg::CMD_IF_COND, sdci_pkg::IF_COND_ARG,
                     sdci_pkg::RESP_R48, 1'b1, 1'b1, sdci_pkg::ERR_NONE, 1'b0, '0, '0));
    add_row(sdci_pkg::OP_OK, 32'h0000_01AB, '0, '0, '0, 1'b1, 1'b1, // bad echo
            mk_reply(sdci_pkg::STATUS_FAILED, '0, '0, sdci_pkg::RESP_NONE, 1'b0, 1'b0,
                     sdci_pkg::ERR_CHECK, 1'b0, '0, '0));
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b1, 1'b0, '0);     // done after failure
    add_row(sdci_pkg::OP_START, '0, '0, '0, '0, 1'b1, 1'b1,
            mk_reply(sdci_pkg::STATUS_ISSUE, sdci_pkg::CMD_GO_IDLE, '0, sdci_pkg::RESP_NONE,
                     1'b0, 1'b0, sdci_pkg::ERR_NONE, 1'b0, '0, '0));
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b0, 1'b0, '0);     // CMD0 done
    add_row(sdci_pkg::OP_OK, 32'hFFFF_FFAA, '1, '1, '1, 1'b0, 1'b0, '0); // echo ok
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b0, 1'b0, '0);     // CMD55 done
    add_row(sdci_pkg::OP_OK, 32'h0000_0000, '0, '0, '0, 1'b0, 1'b0, '0); // card busy
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b0, 1'b0, '0);
    add_row(sdci_pkg::OP_OK, 32'hC000_0000, '0, '0, '0, 1'b0, 1'b0, '0); // block mode
    add_row(sdci_pkg::OP_OK, '1, '1, '1, '1, 1'b0, 1'b0, '0);     // CMD2 done
    add_row(sdci_pkg::OP_OK, 32'hFFFF_0000, '0, '0, '0, 1'b0, 1'b0, '0); // largest address
    add_row(sdci_pkg::OP_OK, '0, 32'h3FFF_FF00, '0, 32'h0040_0000, // largest v1 C_SIZE
            1'b0, 1'b0, '0);
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b0, 1'b0, '0);     // CMD7 done
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b1, 1'b1,
            mk_reply(sdci_pkg::STATUS_READY, '0, '0, sdci_pkg::RESP_NONE, 1'b0, 1'b0,
                     sdci_pkg::ERR_NONE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
    add_row(sdci_pkg::OP_OK, '0, '0, '0, '0, 1'b1, 1'b0, '0);     // done while ready
    add_row(sdci_pkg::OP_START, '0, '0, '0, '0, 1'b1, 1'b1,       // state cleared
            mk_reply(sdci_pkg::STATUS_ISSUE, sdci_pkg::CMD_GO_IDLE, '0, sdci_pkg::RESP_NONE,
                     1'b0, 1'b0, sdci_pkg::ERR_NONE, 1'b0, '0, '0));
    add_row(sdci_pkg::OP_FAIL, '0, '0, '0, '0, 1'b1, 1'b1,
            mk_reply(sdci_pkg::STATUS_FAILED, '0, '0, sdci_pkg::RESP_NONE, 1'b0, 1'b0,
                     sdci_pkg::ERR_CMD_FAIL, 1'b0, '0, '0));

    while (!rst_n) @(posedge clk_i);
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].op, directed_rows[i].w0, directed_rows[i].w1,
                 directed_rows[i].w2, directed_rows[i].w3, directed_rows[i].typed,
                 directed_rows[i].want_made, directed_rows[i].want, made);
    end

    // Random phases. Each one starts from an idle block, takes a register
    // setting, then runs mostly well-formed sequences with random content.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: ;  // keep the reset values
        1: program_regs(8'd1, 32'h0, 16'd1, 32'h0);
        2: program_regs(8'd255, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        3: program_regs(8'd0, $urandom, 16'($urandom), $urandom);
        default: program_regs(8'($urandom_range(1, 4)), $urandom,
                              16'($urandom_range(1, 65535)), $urandom);
      endcase
      ready_pct = (ph == 0 || ph == 2) ? 45 : 30;
      gaps_on   = (ph != 7);  // last phase runs at full rate
      useful    = 0;
      while (useful < EVENTS_PER_PHASE) begin
        draw = $urandom_range(0, 99);
        op   = sdci_pkg::OP_OK;
        w0   = rand_word();
        w1   = rand_word();
        w2   = rand_word();
        w3   = rand_word();
        if (draw < 2) begin
          op = OP_UNUSED;
        end else if (draw < 4) begin
          op = sdci_pkg::OP_FAIL;
        end else if (draw < 5) begin
          op = sdci_pkg::OP_START;
        end else begin
          case (card_phase)
            SEQ_IDLE, SEQ_READY, SEQ_FAILED: begin
              if (draw < 92) op = sdci_pkg::OP_START;
              else if (draw < 96) op = sdci_pkg::OP_FAIL;
            end
            SEQ_CMD8: begin
              if (draw < 92) w0[7:0] = sdci_pkg::CHECK_PATTERN;
            end
            SEQ_ACMD41: begin
              w0[31] = ($urandom_range(0, 99) < ready_pct);
            end
            SEQ_CMD9: begin
              w3[23:22] = 2'($urandom_range(0, 3));
            end
            default: ;
          endcase
        end
        send_event(op, w0, w1, w2, w3, 1'b0, 1'b0, '0, made);
        if (made) useful++;
      end
    end

    settle();
    mismatches += replies_owed.size();

    $display("ran %0d events (%0d dropped by design) under %0d register settings",
             events_sent, ignored_events, settings_used);
    $display("checked %0d replies, %0d card ready and %0d sequence failed",
             replies_seen, ready_seen, failed_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sdci_pkg.sv
hdl/sd_card_init_sequencer.sv
test/sd_card_init_sequencer_tb.sv
